[hdl/cdte_pkg.sv]
// ---------------------------------------------------------------------------
// cdte_pkg: shared types and constants for the date to epoch converter
// Field widths, stage payload structs, month table and scale factors.
// ---------------------------------------------------------------------------
package cdte_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 8;
	localparam int DAY_W   = 8;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int MSEC_W  = 10;
	localparam int OUT_W   = 49;

	// ceil(year/100) via reciprocal multiply, exact for operands below 2^15
	localparam int YP_W          = YEAR_W + 1;
	localparam int DIV_PROD_W    = 2 * YP_W;
	localparam int DIV100_SHIFT  = 21;
	localparam logic [YP_W-1:0] DIV100_RECIP = 15'd20972;
	localparam int Q_W           = 8;

	localparam int DOY_W  = 9;
	localparam int LEAP_W = 13;
	localparam int Y365_W = 23;
	localparam int DAYS_W = 25;
	localparam int TOD_W  = 27;
	localparam int MSD_W  = 28;
	localparam int SUM_W  = DAYS_W + MSD_W;

	localparam logic [TOD_W-1:0] MS_PER_HOUR = 27'd3600000;
	localparam logic [TOD_W-1:0] MS_PER_MIN  = 27'd60000;
	localparam logic [TOD_W-1:0] MS_PER_SEC  = 27'd1000;
	localparam logic signed [MSD_W-1:0] MS_PER_DAY = 28'sd86400000;

	localparam logic signed [SUM_W-1:0] OUT_MAX = 53'sh0_FFFF_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0] OUT_MIN = -OUT_MAX - 53'sd1;

	// days before the first of each month in a common year
	localparam logic [DOY_W-1:0] MONTH_BASE [0:11] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [Q_W-1:0]    cent;       // ceil(year / 100)
		logic [DOY_W-1:0]  doy;        // day index within a common year
		logic              after_feb;  // month is March or later
		logic [TOD_W-1:0]  tod;        // time of day in ms
	} s1_t;

	typedef struct packed {
		logic signed [DAYS_W-1:0] days;
		logic [TOD_W-1:0]         tod;
	} s2_t;

endpackage

[hdl/cdte_decode.sv]
// ---------------------------------------------------------------------------
// cdte_decode: first stage of the converter
// Clamps month and day, looks up the month base, divides the year by 100
// and folds the time of day into milliseconds.
// ---------------------------------------------------------------------------
module cdte_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [cdte_pkg::YEAR_W-1:0]   year,
	input  logic [cdte_pkg::MONTH_W-1:0]  month,
	input  logic [cdte_pkg::DAY_W-1:0]    day,
	input  logic [cdte_pkg::HOUR_W-1:0]   hour,
	input  logic [cdte_pkg::MIN_W-1:0]    minute,
	input  logic [cdte_pkg::SEC_W-1:0]    second,
	input  logic [cdte_pkg::MSEC_W-1:0]   millisecond,
	output logic                          valid_s1,
	output cdte_pkg::s1_t                 data_s1
);

	logic [3:0]                          month_c;
	logic [4:0]                          day_c;
	logic [3:0]                          month_idx;
	logic [cdte_pkg::YP_W-1:0]           year_p99;
	logic [cdte_pkg::DIV_PROD_W-1:0]     div_prod;
	cdte_pkg::s1_t                       nxt;

	// clamp month to 1..12 and day to 1..31
	always_comb begin
		if (month == '0)
			month_c = 4'd1;
		else if (month > 8'd12)
			month_c = 4'd12;
		else
			month_c = month[3:0];
		if (day == '0)
			day_c = 5'd1;
		else if (day > 8'd31)
			day_c = 5'd31;
		else
			day_c = day[4:0];
	end

	assign month_idx = month_c - 4'd1;

	// ceil(year/100) = floor((year + 99) * recip >> shift)
	assign year_p99 = {1'b0, year} + cdte_pkg::YP_W'(99);
	assign div_prod = cdte_pkg::DIV_PROD_W'(year_p99)
		* cdte_pkg::DIV_PROD_W'(cdte_pkg::DIV100_RECIP);

	// assemble the stage payload
	always_comb begin
		nxt.year      = year;
		nxt.cent      = div_prod[cdte_pkg::DIV100_SHIFT +: cdte_pkg::Q_W];
		nxt.doy       = cdte_pkg::MONTH_BASE[month_idx]
			+ cdte_pkg::DOY_W'(day_c - 5'd1);
		nxt.after_feb = (month_c > 4'd2);
		nxt.tod       = cdte_pkg::TOD_W'(hour) * cdte_pkg::MS_PER_HOUR
			+ cdte_pkg::TOD_W'(minute) * cdte_pkg::MS_PER_MIN
			+ cdte_pkg::TOD_W'(second) * cdte_pkg::MS_PER_SEC
			+ cdte_pkg::TOD_W'(millisecond);
	end

	// advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_valid;
	end

	// hold the payload of the beat in flight
	always_ff @(posedge clk) begin
		if (in_valid)
			data_s1 <= nxt;
	end

endmodule

[hdl/cdte_days.sv]
// ---------------------------------------------------------------------------
// cdte_days: second stage of the converter
// Decides the leap year, counts leap days before the year and forms the
// signed day count relative to the epoch year.
// ---------------------------------------------------------------------------
module cdte_days #(
	parameter int EPOCH_YEAR = 1970
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  cdte_pkg::s1_t  data_s1,
	output logic           valid_s2,
	output cdte_pkg::s2_t  data_s2
);

	// days from 0001-style year zero to the first of the epoch year
	localparam int EpochDays = 365 * EPOCH_YEAR + (EPOCH_YEAR + 3) / 4
		- (EPOCH_YEAR + 99) / 100 + (EPOCH_YEAR + 399) / 400;

	logic [cdte_pkg::YP_W-1:0]    cent_x100;
	logic                         div100;
	logic                         leap;
	logic [cdte_pkg::LEAP_W-1:0]  leaps;
	logic [cdte_pkg::Y365_W-1:0]  year365;
	cdte_pkg::s2_t                nxt;

	// year divisible by 100 exactly when ceil(year/100)*100 equals it
	assign cent_x100 = cdte_pkg::YP_W'(data_s1.cent) * cdte_pkg::YP_W'(100);
	assign div100    = (cent_x100 == {1'b0, data_s1.year});
	assign leap      = ((data_s1.year[1:0] == 2'b00) && !div100)
		|| (div100 && (data_s1.cent[1:0] == 2'b00));

	// leap years in 0 .. year-1: ceil(y/4) - ceil(y/100) + ceil(y/400)
	assign leaps = cdte_pkg::LEAP_W'(({1'b0, data_s1.year} + cdte_pkg::YP_W'(3)) >> 2)
		- cdte_pkg::LEAP_W'(data_s1.cent)
		+ cdte_pkg::LEAP_W'(({1'b0, data_s1.cent} + 9'd3) >> 2);

	assign year365 = cdte_pkg::Y365_W'(data_s1.year) * cdte_pkg::Y365_W'(365);

	// sum the day count
	always_comb begin
		nxt.days = cdte_pkg::DAYS_W'(year365)
			+ cdte_pkg::DAYS_W'(leaps)
			+ cdte_pkg::DAYS_W'(data_s1.doy)
			+ cdte_pkg::DAYS_W'(leap && data_s1.after_feb)
			- cdte_pkg::DAYS_W'(EpochDays);
		nxt.tod  = data_s1.tod;
	end

	// advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			data_s2 <= nxt;
	end

endmodule

[hdl/cdte_scale.sv]
// ---------------------------------------------------------------------------
// cdte_scale: last two stages of the converter
// Scales days to milliseconds, adds the time of day and saturates to the
// signed 49-bit result range.
// ---------------------------------------------------------------------------
module cdte_scale (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_s2,
	input  cdte_pkg::s2_t                       data_s2,
	output logic                                done,
	output logic signed [cdte_pkg::OUT_W-1:0]   epoch_ms
);

	logic                                valid_s3;
	logic signed [cdte_pkg::SUM_W-1:0]   prod_s3;
	logic [cdte_pkg::TOD_W-1:0]          tod_s3;
	logic signed [cdte_pkg::SUM_W-1:0]   prod;
	logic signed [cdte_pkg::SUM_W-1:0]   sum;
	logic signed [cdte_pkg::SUM_W-1:0]   sat;

	assign prod = cdte_pkg::SUM_W'(data_s2.days) * cdte_pkg::SUM_W'(cdte_pkg::MS_PER_DAY);

	// add time of day and clamp to the output range
	assign sum = prod_s3
		+ $signed({{(cdte_pkg::SUM_W - cdte_pkg::TOD_W){1'b0}}, tod_s3});

	always_comb begin
		if (sum > cdte_pkg::OUT_MAX)
			sat = cdte_pkg::OUT_MAX;
		else if (sum < cdte_pkg::OUT_MIN)
			sat = cdte_pkg::OUT_MIN;
		else
			sat = sum;
	end

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			done     <= valid_s3;
		end
	end

	// hold the product and the result of each beat
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			prod_s3 <= prod;
			tod_s3  <= data_s2.tod;
		end
		if (valid_s3)
			epoch_ms <= sat[cdte_pkg::OUT_W-1:0];
	end

endmodule

[hdl/civil_date_to_epoch_ms.sv]
// ---------------------------------------------------------------------------
// civil_date_to_epoch_ms: Gregorian date and time to epoch milliseconds
// Pulse start with a date and time of day; done then pulses
// for one cycle with epoch_ms, signed milliseconds since EPOCH_YEAR-01-01.
//
// Channels: the input beat is taken at an edge with start high and busy
// low. busy is always low: a new beat may enter in every cycle.
// Throughput: 1 beat per cycle.
// Stages: clamp and divide year by 100, day count, day-to-ms multiply,
// time-of-day add with saturation. The 25 x 28 bit multiply sets the
// depth of the third stage.
// Reset: arst_n clears all valid bits at once; nothing is in flight after.
// Results are not held: done marks each result for exactly one cycle and
// the receiver must take it then.
// ---------------------------------------------------------------------------
module civil_date_to_epoch_ms #(
	parameter int EPOCH_YEAR = 1970
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [cdte_pkg::YEAR_W-1:0]         year,
	input  logic [cdte_pkg::MONTH_W-1:0]        month,
	input  logic [cdte_pkg::DAY_W-1:0]          day,
	input  logic [cdte_pkg::HOUR_W-1:0]         hour,
	input  logic [cdte_pkg::MIN_W-1:0]          minute,
	input  logic [cdte_pkg::SEC_W-1:0]          second,
	input  logic [cdte_pkg::MSEC_W-1:0]         millisecond,
	output logic                                done,
	output logic signed [cdte_pkg::OUT_W-1:0]   epoch_ms
);

	logic           accept;
	logic           valid_s1;
	logic           valid_s2;
	cdte_pkg::s1_t  data_s1;
	cdte_pkg::s2_t  data_s2;

	// the pipeline never backs up
	assign busy   = 1'b0;
	assign accept = start && !busy;

	cdte_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (accept),
		.year        (year),
		.month       (month),
		.day         (day),
		.hour        (hour),
		.minute      (minute),
		.second      (second),
		.millisecond (millisecond),
		.valid_s1    (valid_s1),
		.data_s1     (data_s1)
	);

	cdte_days #(
		.EPOCH_YEAR (EPOCH_YEAR)
	) u_days (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	cdte_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.done     (done),
		.epoch_ms (epoch_ms)
	);

endmodule

[hdl/cdte_checker.sv]
// ---------------------------------------------------------------------------
// cdte_checker: port-level checks for the date to epoch converter
// Watches the command and result ports for beat count and latency.
// ---------------------------------------------------------------------------
module cdte_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// every accepted beat yields a result on done
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("accepted beat produced no result");

	// no result without a matching accepted beat
	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result without matching beat");

	// busy stays low whenever start or done is high
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start || done) |-> !busy)
		else $error("block refused a beat");

endmodule

bind civil_date_to_epoch_ms cdte_checker u_cdte_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

[verif/civil_date_to_epoch_ms_tb.sv]
// ---------------------------------------------------------------------------
// civil_date_to_epoch_ms_tb: self-checking bench for the date to epoch block
// Drives date and time beats through the start/busy handshake, predicts each
// epoch_ms from the calendar rules (clamping, day rollover, leap years,
// saturation) and checks every done-marked result in order against it.
// A directed set covers field extremes and calendar corners, then random
// beats follow with random sender gaps and one long gap-free stretch.
// ---------------------------------------------------------------------------
module civil_date_to_epoch_ms_tb;

	localparam int EPOCH_YEAR  = 1970;
	localparam int CYCLE_LIMIT = 20000;
	localparam int RANDOM_BEATS = 100;

	typedef struct {
		logic [cdte_pkg::YEAR_W-1:0]  year;
		logic [cdte_pkg::MONTH_W-1:0] month;
		logic [cdte_pkg::DAY_W-1:0]   day;
		logic [cdte_pkg::HOUR_W-1:0]  hour;
		logic [cdte_pkg::MIN_W-1:0]   minute;
		logic [cdte_pkg::SEC_W-1:0]   second;
		logic [cdte_pkg::MSEC_W-1:0]  msec;
	} date_beat_t;

	// Expected epoch times in beat order, plus mismatch bookkeeping
	class epoch_ms_checker;
		logic signed [cdte_pkg::OUT_W-1:0] expected_ms_q [$];
		int errors = 0;
		int month_days [2][12] = '{
			'{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31},
			'{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31}
		};

		// leap years in 0 .. y-1
		function longint leap_years_before(longint y);
			if (y <= 0)
				return 0;
			return (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		endfunction

		function int pending();
			return expected_ms_q.size();
		endfunction

		// Work out the epoch time of an accepted beat and queue it
		function void note_date(date_beat_t b);
			longint y;
			longint mo;
			longint d;
			longint days;
			longint ms;
			int leap;
			longint sat_hi;
			longint sat_lo;
			y = longint'(b.year);
			mo = longint'(b.month);
			d = longint'(b.day);
			sat_hi = 64'sh0000_FFFF_FFFF_FFFF;
			sat_lo = -sat_hi - 1;
			// clamp month and day
			if (mo < 1) mo = 1;
			if (mo > 12) mo = 12;
			if (d < 1) d = 1;
			if (d > 31) d = 31;
			leap = (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 1 : 0;
			days = d - 1;
			for (int m = 0; m + 1 < mo; m++)
				days += month_days[leap][m];
			days += 365 * (y - EPOCH_YEAR) + leap_years_before(y)
				- leap_years_before(EPOCH_YEAR);
			// time fields carry as given, no clamping
			ms = days * 64'sd86400000 + longint'(b.hour) * 64'sd3600000
				+ longint'(b.minute) * 64'sd60000 + longint'(b.second) * 64'sd1000
				+ longint'(b.msec);
			if (ms > sat_hi) ms = sat_hi;
			if (ms < sat_lo) ms = sat_lo;
			expected_ms_q.push_back(ms[cdte_pkg::OUT_W-1:0]);
		endfunction

		// Compare one result beat with the oldest expectation
		function void check_epoch_ms(logic signed [cdte_pkg::OUT_W-1:0] actual);
			logic signed [cdte_pkg::OUT_W-1:0] want;
			if (expected_ms_q.size() == 0) begin
				if (errors < 10)
					$display("epoch_ms %0d arrived with nothing expected", actual);
				errors++;
				return;
			end
			want = expected_ms_q.pop_front();
			if (actual !== want) begin
				if (errors < 10)
					$display("epoch_ms mismatch: expected %0d, got %0d", want, actual);
				errors++;
			end
		endfunction
	endclass

	logic                               clk;
	logic                               arst_n;
	logic                               start;
	logic                               busy;
	logic [cdte_pkg::YEAR_W-1:0]        year;
	logic [cdte_pkg::MONTH_W-1:0]       month;
	logic [cdte_pkg::DAY_W-1:0]         day;
	logic [cdte_pkg::HOUR_W-1:0]        hour;
	logic [cdte_pkg::MIN_W-1:0]         minute;
	logic [cdte_pkg::SEC_W-1:0]         second;
	logic [cdte_pkg::MSEC_W-1:0]        millisecond;
	logic                               done;
	logic signed [cdte_pkg::OUT_W-1:0]  epoch_ms;

	int cycles = 0;
	epoch_ms_checker chk = new;

	civil_date_to_epoch_ms #(
		.EPOCH_YEAR(EPOCH_YEAR)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.year(year),
		.month(month),
		.day(day),
		.hour(hour),
		.minute(minute),
		.second(second),
		.millisecond(millisecond),
		.done(done),
		.epoch_ms(epoch_ms)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Take each result beat in the cycle done marks it
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			chk.check_epoch_ms(epoch_ms);
	end

	function automatic date_beat_t mk_date(int y, int mo, int d, int h, int mi, int s,
			int ms);
		date_beat_t b;
		b.year = y[cdte_pkg::YEAR_W-1:0];
		b.month = mo[cdte_pkg::MONTH_W-1:0];
		b.day = d[cdte_pkg::DAY_W-1:0];
		b.hour = h[cdte_pkg::HOUR_W-1:0];
		b.minute = mi[cdte_pkg::MIN_W-1:0];
		b.second = s[cdte_pkg::SEC_W-1:0];
		b.msec = ms[cdte_pkg::MSEC_W-1:0];
		return b;
	endfunction

	// Present one beat, idling a random number of cycles first if may_idle is set, and hold it until taken
	task automatic drive_date(input date_beat_t b, input bit may_idle);
		while (may_idle && $urandom_range(99) < 33) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		year <= b.year;
		month <= b.month;
		day <= b.day;
		hour <= b.hour;
		minute <= b.minute;
		second <= b.second;
		millisecond <= b.msec;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		chk.note_date(b);
	endtask

	// Drop start and hold off until every queued result has come back
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (chk.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		date_beat_t directed_q [$];
		date_beat_t b;
		bit wild;

		arst_n = 1'b0;
		start = 1'b0;
		year = '0;
		month = '0;
		day = '0;
		hour = '0;
		minute = '0;
		second = '0;
		millisecond = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// calendar corners and field extremes
		directed_q.push_back(mk_date(1970, 1, 1, 0, 0, 0, 0));
		directed_q.push_back(mk_date(1969, 12, 31, 23, 59, 59, 999));
		directed_q.push_back(mk_date(1, 1, 1, 0, 0, 0, 0));
		directed_q.push_back(mk_date(9999, 12, 31, 23, 59, 59, 999));
		directed_q.push_back(mk_date(0, 0, 0, 0, 0, 0, 0));
		directed_q.push_back(mk_date(16383, 255, 255, 31, 63, 63, 1023));
		directed_q.push_back(mk_date(2000, 2, 29, 12, 0, 0, 0));
		directed_q.push_back(mk_date(1900, 2, 29, 0, 0, 0, 1));
		directed_q.push_back(mk_date(2023, 2, 31, 6, 30, 0, 0));
		directed_q.push_back(mk_date(2024, 13, 5, 1, 2, 3, 4));
		directed_q.push_back(mk_date(2024, 0, 5, 1, 2, 3, 4));
		directed_q.push_back(mk_date(2024, 7, 0, 0, 0, 0, 0));
		directed_q.push_back(mk_date(2024, 7, 200, 0, 0, 0, 0));
		directed_q.push_back(mk_date(1970, 1, 1, 31, 63, 63, 1023));
		directed_q.push_back(mk_date(0, 3, 1, 0, 0, 0, 0));
		directed_q.push_back(mk_date(10500, 6, 15, 8, 0, 0, 0));
		directed_q.push_back(mk_date(12000, 1, 1, 0, 0, 0, 0));
		directed_q.push_back(mk_date(1600, 12, 31, 23, 59, 59, 999));
		directed_q.push_back(mk_date(2100, 3, 1, 0, 0, 0, 0));
		directed_q.push_back(mk_date(1, 12, 31, 23, 59, 59, 999));
		foreach (directed_q[i])
			drive_date(directed_q[i], 1'b1);

		// hold off until the pipeline is empty before the random part
		drain_results();

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			wild = ($urandom_range(99) < 15);
			case ($urandom_range(3))
				0: b.year = cdte_pkg::YEAR_W'($urandom_range(16383));
				1: b.year = cdte_pkg::YEAR_W'($urandom_range(1900, 2100));
				default: b.year = cdte_pkg::YEAR_W'($urandom_range(1, 9999));
			endcase
			b.month = wild ? cdte_pkg::MONTH_W'($urandom_range(255))
				: cdte_pkg::MONTH_W'($urandom_range(1, 12));
			b.day = ($urandom_range(99) < 15) ? cdte_pkg::DAY_W'($urandom_range(255))
				: cdte_pkg::DAY_W'($urandom_range(1, 31));
			b.hour = wild ? cdte_pkg::HOUR_W'($urandom_range(31))
				: cdte_pkg::HOUR_W'($urandom_range(23));
			b.minute = wild ? cdte_pkg::MIN_W'($urandom_range(63))
				: cdte_pkg::MIN_W'($urandom_range(59));
			b.second = wild ? cdte_pkg::SEC_W'($urandom_range(63))
				: cdte_pkg::SEC_W'($urandom_range(59));
			b.msec = wild ? cdte_pkg::MSEC_W'($urandom_range(1023))
				: cdte_pkg::MSEC_W'($urandom_range(999));
			// beats 40 through 69 go back to back
			drive_date(b, !(i >= 40 && i < 70));
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (chk.errors == 0 && chk.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
